[rtl/ssi_pkg.sv]
// ----------------------------------------------------------------------------
// ssi_pkg
// Shared constants and types of the streaming Simpson integrator.
// ----------------------------------------------------------------------------
package ssi_pkg;

  // defaults for the top-level parameters
  localparam int MAX_POINTS_DEF   = 4096;
  localparam int SAMPLE_BITS_DEF  = 24;

  // fixed field widths
  localparam int AREA_BITS        = 56;
  localparam int CFG_BITS         = 32;

  // cell width after reset: 1.0 in Q16.16
  localparam logic [CFG_BITS-1:0] CELL_WIDTH_RESET = 32'h0001_0000;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH      = 4;

  // bits retired per stage of the divide-by-three pipeline
  localparam int DIGIT_BITS       = 8;

  // how a finished series is to be turned into a result word
  typedef struct packed {
    logic force_zero;  // area is zero, no arithmetic
    logic force_ovf;   // overflow flag for a forced result
  } ssi_flags_t;

  localparam int FLAGS_BITS = $bits(ssi_flags_t);

endpackage

[rtl/simpson_stream_integrator_unit.sv]
// throughput: one sample word per cycle while the queue is not full; the
//   multiply and divide-by-six path is fully pipelined and stalls only
//   while a waiting result is not taken
// reset: synchronous rst_n clears the series, the queue and the pipeline
//   valids, and sets the cell width to 1.0
// ----------------------------------------------------------------------------
// simpson_stream_integrator_unit
// Streaming composite Simpson integrator with saturated Q16 result.
// ----------------------------------------------------------------------------
module simpson_stream_integrator_unit #(
  parameter int MAX_POINTS  = ssi_pkg::MAX_POINTS_DEF,
  parameter int SAMPLE_BITS = ssi_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic signed [ssi_pkg::CFG_BITS-1:0]  cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample,
  input  logic                                 in_last,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [ssi_pkg::AREA_BITS-1:0] out_area,
  output logic                                 out_overflow
);
  import ssi_pkg::*;

  localparam int ACC_W  = SAMPLE_BITS + $clog2(MAX_POINTS) + 3;
  localparam int TRAP_W = SAMPLE_BITS + 1;
  localparam int ENT_W  = FLAGS_BITS + ACC_W + 1 + TRAP_W;

  logic                     take;
  logic                     push;
  logic signed [ACC_W:0]    f_acc;
  logic signed [TRAP_W-1:0] f_trap;
  ssi_flags_t               f_flags;
  logic [ENT_W-1:0]         q_din;
  logic [ENT_W-1:0]         q_dout;
  logic                     q_not_empty;
  logic                     q_full;
  logic                     q_pop;
  logic signed [ACC_W:0]    b_acc;
  logic signed [TRAP_W-1:0] b_trap;
  ssi_flags_t               b_flags;

  // a word is taken whenever the queue can hold a finished series
  assign in_ready = ~q_full;
  assign take     = in_valid & ~q_full;

  ssi_front #(
    .MAX_POINTS  (MAX_POINTS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (take),
    .sample (in_sample),
    .last   (in_last),
    .push   (push),
    .acc    (f_acc),
    .trap   (f_trap),
    .flags  (f_flags)
  );

  // queue entry packing
  assign q_din = {f_flags, f_acc, f_trap};

  ssi_fifo #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .din       (q_din),
    .pop       (q_pop),
    .dout      (q_dout),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  assign b_flags = q_dout[ENT_W-1 -: FLAGS_BITS];
  assign b_acc   = q_dout[TRAP_W +: ACC_W+1];
  assign b_trap  = q_dout[TRAP_W-1:0];

  ssi_back #(
    .MAX_POINTS  (MAX_POINTS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .q_valid      (q_not_empty),
    .q_pop        (q_pop),
    .q_acc        (b_acc),
    .q_trap       (b_trap),
    .q_flags      (b_flags),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_area     (out_area),
    .out_overflow (out_overflow)
  );

endmodule

[rtl/ssi_front.sv]
// ----------------------------------------------------------------------------
// ssi_front
// Accepts samples, keeps the running Simpson weighted sum and, on the last
// sample of a series, classifies it and hands the closing terms to the queue.
// ----------------------------------------------------------------------------
module ssi_front #(
  parameter int MAX_POINTS  = ssi_pkg::MAX_POINTS_DEF,
  parameter int SAMPLE_BITS = ssi_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  logic                                                   take,
  input  logic signed [SAMPLE_BITS-1:0]                          sample,
  input  logic                                                   last,
  output logic                                                   push,
  output logic signed [SAMPLE_BITS+$clog2(MAX_POINTS)+3:0]       acc,
  output logic signed [SAMPLE_BITS:0]                            trap,
  output ssi_pkg::ssi_flags_t                                    flags
);
  import ssi_pkg::*;

  localparam int ACC_W  = SAMPLE_BITS + $clog2(MAX_POINTS) + 3;
  localparam int TRAP_W = SAMPLE_BITS + 1;
  localparam int IDX_W  = $clog2(MAX_POINTS + 1);

  logic signed [ACC_W-1:0]       ws_r, ws_nxt;
  logic signed [SAMPLE_BITS-1:0] prev_r, prev_nxt;
  logic [IDX_W-1:0]              idx_r, idx_nxt;
  logic                          exc_r, exc_nxt;

  logic                          full;
  logic signed [ACC_W-1:0]       y_ext;
  logic signed [ACC_W-1:0]       term;

  assign full  = (idx_r == IDX_W'(MAX_POINTS));
  assign y_ext = ACC_W'(sample);

  // weight 1 for the first sample, then 4 and 2 in turn
  always_comb begin
    if (idx_r == '0) begin
      term = y_ext;
    end else if (idx_r[0]) begin
      term = y_ext <<< 2;
    end else begin
      term = y_ext <<< 1;
    end
  end

  // closing terms of the series
  always_comb begin
    if (idx_r[0]) begin
      acc  = (ACC_W+1)'(ws_r) - (ACC_W+1)'(prev_r);
      trap = TRAP_W'(prev_r) + TRAP_W'(sample);
    end else begin
      acc  = (ACC_W+1)'(ws_r) + (ACC_W+1)'(sample);
      trap = '0;
    end
    flags.force_ovf  = exc_r | full;
    flags.force_zero = exc_r | full | (idx_r == '0);
  end

  assign push = take & last;

  // series state update
  always_comb begin
    ws_nxt   = ws_r;
    prev_nxt = prev_r;
    idx_nxt  = idx_r;
    exc_nxt  = exc_r;
    if (take) begin
      if (last) begin
        ws_nxt   = '0;
        prev_nxt = '0;
        idx_nxt  = '0;
        exc_nxt  = 1'b0;
      end else if (full) begin
        exc_nxt  = 1'b1;
      end else begin
        ws_nxt   = ws_r + term;
        prev_nxt = sample;
        idx_nxt  = idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r   <= '0;
      prev_r <= '0;
      idx_r  <= '0;
      exc_r  <= 1'b0;
    end else begin
      ws_r   <= ws_nxt;
      prev_r <= prev_nxt;
      idx_r  <= idx_nxt;
      exc_r  <= exc_nxt;
    end
  end

endmodule

[rtl/ssi_fifo.sv]
// ----------------------------------------------------------------------------
// ssi_fifo
// Small register queue that decouples the accumulator from the scaling pipe.
// ----------------------------------------------------------------------------
module ssi_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = ssi_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             not_empty,
  output logic             full
);
  import ssi_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign do_push   = push & ~full;
  assign do_pop    = pop & not_empty;
  assign dout      = mem_r[rd_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= din;
    end
  end

endmodule

[rtl/ssi_back.sv]
// ----------------------------------------------------------------------------
// ssi_back
// Scaling pipeline: forms 2*acc+3*trap, multiplies by the cell width in
// 32-bit partial products, divides by six digit by digit and saturates.
// ----------------------------------------------------------------------------
module ssi_back #(
  parameter int MAX_POINTS  = ssi_pkg::MAX_POINTS_DEF,
  parameter int SAMPLE_BITS = ssi_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             cfg_we,
  input  logic signed [ssi_pkg::CFG_BITS-1:0]              cfg_wdata,
  input  logic                                             q_valid,
  output logic                                             q_pop,
  input  logic signed [SAMPLE_BITS+$clog2(MAX_POINTS)+3:0] q_acc,
  input  logic signed [SAMPLE_BITS:0]                      q_trap,
  input  ssi_pkg::ssi_flags_t                              q_flags,
  output logic                                             out_valid,
  input  logic                                             out_ready,
  output logic signed [ssi_pkg::AREA_BITS-1:0]             out_area,
  output logic                                             out_overflow
);
  import ssi_pkg::*;

  localparam int ACC_W  = SAMPLE_BITS + $clog2(MAX_POINTS) + 3;
  localparam int NUM_W  = ACC_W + 3;
  localparam int NCH    = (NUM_W + 31) / 32;
  localparam int NPAD   = NCH * 32;
  localparam int PM_W   = CFG_BITS + NUM_W;
  localparam int D_W    = PM_W - 1;
  localparam int D_STG  = (D_W + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int DP_W   = D_STG * DIGIT_BITS;
  localparam int CMP_W  = (DP_W > AREA_BITS + 1) ? DP_W : AREA_BITS + 1;

  // one digit of long division by three, most significant bit first
  function automatic logic [DIGIT_BITS+1:0] div3_digit(input logic [1:0] rem_in,
                                                       input logic [DIGIT_BITS-1:0] dig);
    logic [2:0]            r;
    logic [DIGIT_BITS-1:0] q;
    r = {1'b0, rem_in};
    q = '0;
    for (int b = DIGIT_BITS - 1; b >= 0; b--) begin
      r = {r[1:0], dig[b]};
      if (r >= 3'd3) begin
        q[b] = 1'b1;
        r    = r - 3'd3;
      end
    end
    return {r[1:0], q};
  endfunction

  logic adv;

  // cell width register
  logic signed [CFG_BITS-1:0] cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CELL_WIDTH_RESET;
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  // whole pipe moves when the output register is free or being emptied
  logic out_valid_r;
  assign adv   = ~out_valid_r | out_ready;
  assign q_pop = adv & q_valid;

  // stage 0: numerator 2*acc + 3*trap
  logic                    v0_r;
  logic signed [NUM_W-1:0] num0_r;
  ssi_flags_t              fl0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num0_r <= (NUM_W'(q_acc) <<< 1) + (NUM_W'(q_trap) <<< 1) + NUM_W'(q_trap);
      fl0_r  <= q_flags;
    end
  end

  // stage 1: sign and magnitudes
  logic                v1_r;
  logic                neg1_r;
  logic [NUM_W-1:0]    nmag1_r;
  logic [CFG_BITS-1:0] wmag1_r;
  ssi_flags_t          fl1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      neg1_r  <= num0_r[NUM_W-1] ^ cfg_r[CFG_BITS-1];
      nmag1_r <= num0_r[NUM_W-1] ? NUM_W'(-num0_r) : NUM_W'(num0_r);
      wmag1_r <= cfg_r[CFG_BITS-1] ? CFG_BITS'(-cfg_r) : CFG_BITS'(cfg_r);
      fl1_r   <= fl0_r;
    end
  end

  // stage 2: 32 by 32 partial products
  logic             v2_r;
  logic             neg2_r;
  ssi_flags_t       fl2_r;
  logic [63:0]      pp2_r [NCH];
  logic [NPAD-1:0]  npad1;

  assign npad1 = NPAD'(nmag1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      neg2_r <= neg1_r;
      fl2_r  <= fl1_r;
      for (int c = 0; c < NCH; c++) begin
        pp2_r[c] <= 64'(wmag1_r) * 64'(npad1[32*c +: 32]);
      end
    end
  end

  // stage 3: sum partial products, halve for the divide by six
  logic             v3_r;
  logic             neg3_r;
  ssi_flags_t       fl3_r;
  logic [D_W-1:0]   half3_r;
  logic [PM_W-1:0]  pm_sum;

  always_comb begin
    pm_sum = '0;
    for (int c = 0; c < NCH; c++) begin
      pm_sum = pm_sum + (PM_W'(pp2_r[c]) << (32 * c));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      neg3_r  <= neg2_r;
      fl3_r   <= fl2_r;
      half3_r <= pm_sum[PM_W-1:1];
    end
  end

  // divide-by-three stages, one digit each
  logic [DP_W-1:0] dq_o  [D_STG];
  logic [1:0]      rem_o [D_STG];
  logic            neg_o [D_STG];
  logic            v_o   [D_STG];
  ssi_flags_t      fl_o  [D_STG];

  for (genvar j = 0; j < D_STG; j++) begin : g_div
    localparam int POS = DP_W - DIGIT_BITS * (j + 1);

    logic [DP_W-1:0]         din;
    logic [1:0]              rin;
    logic                    nin;
    logic                    vin;
    ssi_flags_t              fin;
    logic [DIGIT_BITS+1:0]   res;
    logic [DP_W-1:0]         dq_nxt;
    logic [DP_W-1:0]         dq_r;
    logic [1:0]              rem_r;
    logic                    neg_r;
    logic                    v_r;
    ssi_flags_t              fl_r;

    if (j == 0) begin : g_first
      assign din = DP_W'(half3_r);
      assign rin = 2'd0;
      assign nin = neg3_r;
      assign vin = v3_r;
      assign fin = fl3_r;
    end else begin : g_next
      assign din = dq_o[j-1];
      assign rin = rem_o[j-1];
      assign nin = neg_o[j-1];
      assign vin = v_o[j-1];
      assign fin = fl_o[j-1];
    end

    assign res = div3_digit(rin, din[POS +: DIGIT_BITS]);

    // quotient word with this stage's digit filled in
    always_comb begin
      dq_nxt                    = din;
      dq_nxt[POS +: DIGIT_BITS] = res[DIGIT_BITS-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (adv) begin
        v_r <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dq_r  <= dq_nxt;
        rem_r <= res[DIGIT_BITS+1:DIGIT_BITS];
        neg_r <= nin;
        fl_r  <= fin;
      end
    end

    assign dq_o[j]  = dq_r;
    assign rem_o[j] = rem_r;
    assign neg_o[j] = neg_r;
    assign v_o[j]   = v_r;
    assign fl_o[j]  = fl_r;
  end

  // saturation and output register
  logic [CMP_W-1:0]           qx;
  logic [CMP_W-1:0]           lim;
  logic                       sat;
  logic signed [AREA_BITS-1:0] area_nxt;
  logic                       ovf_nxt;
  logic signed [AREA_BITS-1:0] area_r;
  logic                       ovf_r;
  logic                       qneg;
  ssi_flags_t                 qfl;

  assign qx   = CMP_W'(dq_o[D_STG-1]);
  assign lim  = CMP_W'(1) << (AREA_BITS - 1);
  assign qneg = neg_o[D_STG-1];
  assign qfl  = fl_o[D_STG-1];

  always_comb begin
    sat = qneg ? (qx > lim) : (qx >= lim);
    if (qfl.force_zero) begin
      area_nxt = '0;
      ovf_nxt  = qfl.force_ovf;
    end else if (sat) begin
      area_nxt = qneg ? {1'b1, {(AREA_BITS-1){1'b0}}} : {1'b0, {(AREA_BITS-1){1'b1}}};
      ovf_nxt  = 1'b1;
    end else begin
      area_nxt = qneg ? -AREA_BITS'(qx) : AREA_BITS'(qx);
      ovf_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v_o[D_STG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      area_r <= area_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_area     = area_r;
  assign out_overflow = ovf_r;

endmodule

[tb/sv/simpson_stream_integrator_unit_checker.sv]
// ----------------------------------------------------------------------------
// simpson_stream_integrator_unit_checker
// Watches the sample, result and width ports of the Simpson integrator. It
// keeps its own running weighted sum per series, works out the saturated area
// word for every series end and compares each returned word with the oldest
// one still waiting.
// ----------------------------------------------------------------------------
module simpson_stream_integrator_unit_checker #(
  parameter int MAX_POINTS  = ssi_pkg::MAX_POINTS_DEF,
  parameter int SAMPLE_BITS = ssi_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic signed [ssi_pkg::CFG_BITS-1:0]  cfg_wdata,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample,
  input  logic                                 in_last,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic signed [ssi_pkg::AREA_BITS-1:0] out_area,
  input  logic                                 out_overflow,
  output int                                   fail_count,
  output int                                   pending_words
);
  timeunit 1ns;
  timeprecision 1ps;

  import ssi_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [AREA_BITS-1:0] area;
    logic                 ovf;
  } area_word_t;

  // predicted series state
  logic signed [CFG_BITS-1:0]    cell_w;
  logic signed [39:0]            run_sum;
  logic signed [SAMPLE_BITS-1:0] prev_word;
  logic [12:0]                   word_count;
  logic                          series_overrun;

  area_word_t area_q[$];
  int         mismatches = 0;

  assign fail_count = mismatches;

  always @(posedge clk) begin
    logic signed [SAMPLE_BITS-1:0] y;
    logic signed [39:0]            y_wide;
    logic signed [39:0]            acc;
    logic signed [SAMPLE_BITS:0]   trap;
    logic signed [47:0]            num;
    logic signed [127:0]           prod;
    logic signed [127:0]           quo;
    logic signed [127:0]           hi;
    logic signed [127:0]           lo;
    logic [12:0]                   k;
    area_word_t                    want;
    if (!rst_n) begin
      cell_w         = CELL_WIDTH_RESET;
      run_sum        = '0;
      prev_word      = '0;
      word_count     = '0;
      series_overrun = 1'b0;
      area_q.delete();
    end else begin
      if (cfg_we) begin
        cell_w = cfg_wdata;
      end

      // returned word against the oldest expected one
      if (out_valid && out_ready) begin
        if (area_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("unexpected area word: area %h ovf %b", out_area, out_overflow);
          end
        end else begin
          want = area_q.pop_front();
          if (out_area !== want.area || out_overflow !== want.ovf) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("area word mismatch: area exp %h got %h, ovf exp %b got %b",
                       want.area, out_area, want.ovf, out_overflow);
            end
          end
        end
      end

      // fold the accepted sample word into the series
      if (in_valid && in_ready) begin
        y      = in_sample;
        y_wide = 40'(y);
        k      = word_count;
        if (k >= MAX_POINTS) begin
          series_overrun = 1'b1;
        end else if (!in_last) begin
          if (k == 0) begin
            run_sum = run_sum + y_wide;
          end else if (k[0]) begin
            run_sum = run_sum + (y_wide <<< 2);
          end else begin
            run_sum = run_sum + (y_wide <<< 1);
          end
          prev_word  = y;
          word_count = k + 13'd1;
        end

        // series end: one area word
        if (in_last) begin
          want.area = '0;
          want.ovf  = 1'b0;
          if (series_overrun) begin
            want.ovf = 1'b1;
          end else if (k != 0) begin
            if (!k[0]) begin
              // odd count, last word closes the simpson part
              acc  = run_sum + y_wide;
              trap = '0;
            end else begin
              // even count, trapezoid over the final interval
              acc  = run_sum - 40'(prev_word);
              trap = (SAMPLE_BITS+1)'(prev_word) + (SAMPLE_BITS+1)'(y);
            end
            num  = (48'(acc) <<< 1) + (48'(trap) <<< 1) + 48'(trap);
            prod = 128'(cell_w);
            prod = prod * 128'(num);
            quo  = prod / 128'sd6;
            hi   = 128'sd1;
            hi   = (hi <<< (AREA_BITS - 1)) - 128'sd1;
            lo   = -hi - 128'sd1;
            // saturate to the area width
            if (quo > hi) begin
              want.area = hi[AREA_BITS-1:0];
              want.ovf  = 1'b1;
            end else if (quo < lo) begin
              want.area = lo[AREA_BITS-1:0];
              want.ovf  = 1'b1;
            end else begin
              want.area = quo[AREA_BITS-1:0];
            end
          end
          area_q.push_back(want);
          run_sum        = '0;
          prev_word      = '0;
          word_count     = '0;
          series_overrun = 1'b0;
        end
      end
    end
    pending_words <= area_q.size();
  end

endmodule

[tb/sv/simpson_stream_integrator_unit_test.sv]
// ----------------------------------------------------------------------------
// simpson_stream_integrator_unit_test
// Drives sample series into the Simpson integrator: a directed set of short
// series at extreme widths and values, then random series under three idling
// patterns. The checker beside the block predicts and compares every area
// word.
// ----------------------------------------------------------------------------
module simpson_stream_integrator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ssi_pkg::*;

  localparam int MAX_POINTS   = MAX_POINTS_DEF;
  localparam int SAMPLE_BITS  = SAMPLE_BITS_DEF;
  localparam int MODE_WORDS   = 470;
  localparam int DRAIN_CYCLES = 32;
  localparam int CYCLE_LIMIT  = 400000;

  localparam logic signed [CFG_BITS-1:0] WIDTH_MAX = {1'b0, {(CFG_BITS-1){1'b1}}};
  localparam logic signed [CFG_BITS-1:0] WIDTH_MIN = {1'b1, {(CFG_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic                          clk          = 1'b0;
  logic                          rst_n        = 1'b0;
  logic                          cfg_we       = 1'b0;
  logic signed [CFG_BITS-1:0]    cfg_wdata    = '0;
  logic                          in_valid     = 1'b0;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] in_sample    = '0;
  logic                          in_last      = 1'b0;
  logic                          out_valid;
  logic                          out_ready    = 1'b0;
  logic signed [AREA_BITS-1:0]   out_area;
  logic                          out_overflow;

  int fail_count;
  int pending_words;
  int gap_pct     = 16;
  int stall_pct   = 65;
  int cycle_count = 0;

  simpson_stream_integrator_unit #(
    .MAX_POINTS  (MAX_POINTS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample    (in_sample),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_area     (out_area),
    .out_overflow (out_overflow)
  );

  simpson_stream_integrator_unit_checker #(
    .MAX_POINTS  (MAX_POINTS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample     (in_sample),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_area      (out_area),
    .out_overflow  (out_overflow),
    .fail_count    (fail_count),
    .pending_words (pending_words)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) begin
      return SAMPLE_MAX;
    end else if (sel < 20) begin
      return SAMPLE_MIN;
    end else if (sel < 30) begin
      return SAMPLE_BITS'($urandom_range(2) - 1);
    end else if (sel < 50) begin
      return SAMPLE_BITS'($urandom_range(2000) - 1000);
    end
    return SAMPLE_BITS'($urandom());
  endfunction

  function automatic int pick_len();
    int sel;
    sel = $urandom_range(99);
    if (sel < 5) begin
      return 1;
    end else if (sel < 10) begin
      return 2;
    end else if (sel < 70) begin
      return $urandom_range(10, 3);
    end else if (sel < 95) begin
      return $urandom_range(40, 11);
    end
    return $urandom_range(200, 41);
  endfunction

  function automatic logic signed [CFG_BITS-1:0] pick_width();
    int sel;
    sel = $urandom_range(99);
    if (sel < 20) begin
      return WIDTH_MAX;
    end else if (sel < 40) begin
      return WIDTH_MIN;
    end else if (sel < 50) begin
      return '0;
    end
    return $urandom();
  endfunction

  // one sample word, valid held until accepted
  task automatic send_word(input logic signed [SAMPLE_BITS-1:0] value, input logic last);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= value;
    in_last   <= last;
    do begin
      @(posedge clk);
    end while (!in_ready);
  endtask

  task automatic send_same(input logic signed [SAMPLE_BITS-1:0] value, input int count);
    for (int i = 1; i <= count; i++) begin
      send_word(value, i == count);
    end
  endtask

  task automatic send_series(input int count);
    for (int i = 1; i <= count; i++) begin
      send_word(pick_sample(), i == count);
    end
  endtask

  // hold the sender until every area word is back, then let the pipe empty
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_width(input logic signed [CFG_BITS-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_random(input int gap, input int stall);
    int sent;
    int len;
    bit paused;
    gap_pct   = gap;
    stall_pct = stall;
    sent      = 0;
    paused    = 1'b0;
    set_width(pick_width());
    while (sent < MODE_WORDS) begin
      len = pick_len();
      send_series(len);
      sent += len;
      // mid-phase pause with a fresh width
      if (!paused && sent >= MODE_WORDS / 2) begin
        wait_drained();
        set_width(pick_width());
        paused = 1'b1;
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed series at the reset width
    gap_pct   = 16;
    stall_pct = 65;
    send_word(SAMPLE_MAX, 1'b1);
    send_word(SAMPLE_BITS'(100), 1'b0);
    send_word(SAMPLE_BITS'(300), 1'b1);
    send_same(SAMPLE_MIN, 3);
    send_word(SAMPLE_BITS'(1), 1'b0);
    send_word(SAMPLE_BITS'(-1), 1'b0);
    send_word(SAMPLE_MAX, 1'b0);
    send_word(SAMPLE_MIN, 1'b1);
    wait_drained();

    // widest positive width, largest positive samples
    set_width(WIDTH_MAX);
    send_same(SAMPLE_MAX, 3);
    send_same(SAMPLE_MAX, 2);
    wait_drained();

    // most negative width, negative saturation
    set_width(WIDTH_MIN);
    send_same(SAMPLE_MAX, 5);
    send_word(SAMPLE_MIN, 1'b1);
    wait_drained();

    // zero width
    set_width('0);
    send_word(SAMPLE_BITS'(12345), 1'b0);
    send_word(SAMPLE_BITS'(-777), 1'b1);
    wait_drained();

    run_random(16, 65);
    run_random(65, 16);
    run_random(0, 0);

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
